FILE: sv/cht_pkg.sv
// Shared types, constants and character-class helpers for the C header tokenizer.
`default_nettype none

package cht_pkg;

  localparam int OffsetBits = 16;
  localparam int OutBits    = 16;
  localparam int WideBits   = 33;

  localparam logic [OffsetBits-1:0] PosMax = {OffsetBits{1'b1}};

  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChBar    = 8'h7C;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChUnder  = 8'h5F;

  localparam logic [2:0] KwLen   = 3'd6;
  localparam logic [2:0] KwNone  = 3'd7;
  localparam logic [1:0] NumDot  = 2'd1;
  localparam logic [1:0] NumHex  = 2'd2;
  localparam logic [1:0] MaxToks = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_LINE    = 4'd1,
    MODE_BLOCK   = 4'd2,
    MODE_BSTAR   = 4'd3,
    MODE_SLASH   = 4'd4,
    MODE_IDENT   = 4'd5,
    MODE_ICOLON  = 4'd6,
    MODE_IDCOLON = 4'd7,
    MODE_NUMBER  = 4'd8,
    MODE_STRING  = 4'd9,
    MODE_PEND    = 4'd10
  } mode_e;

  typedef enum logic [3:0] {
    TOK_EOF     = 4'd0,
    TOK_IDENT   = 4'd1,
    TOK_KEYWORD = 4'd2,
    TOK_INT     = 4'd3,
    TOK_REAL    = 4'd4,
    TOK_QUOTED  = 4'd5,
    TOK_EQEQ    = 4'd6,
    TOK_OR      = 4'd7,
    TOK_AND     = 4'd8,
    TOK_SINGLE  = 4'd9
  } tok_kind_e;

  typedef struct packed {
    mode_e                 mode;
    logic [OffsetBits-1:0] pos;
    logic [OffsetBits-1:0] start;
    logic [1:0]            nflags;
    logic [2:0]            kw;
    logic [7:0]            pend;
    logic                  esc;
  } scan_state_t;

  typedef struct packed {
    tok_kind_e          kind;
    logic [7:0]         chr;
    logic [OutBits-1:0] start;
    logic [OutBits-1:0] len;
    logic               last;
  } token_t;

  typedef struct packed {
    token_t [2:0] t;
    logic [1:0]   n;
  } tok_list_t;

  localparam scan_state_t StateReset = '{
    mode: MODE_IDLE, pos: '0, start: '0, nflags: '0, kw: '0, pend: '0, esc: 1'b0
  };

  function automatic logic is_space(logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == ChUnder);
  endfunction

  function automatic logic is_ident_start(logic [7:0] b);
    return is_alpha(b) || (b == ChUnder) || (b == ChTilde);
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] k);
    case (k)
      3'd0:    return 8'h65;  // e
      3'd1:    return 8'h78;  // x
      3'd2:    return 8'h74;  // t
      3'd3:    return 8'h65;  // e
      3'd4:    return 8'h72;  // r
      3'd5:    return 8'h6E;  // n
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [OutBits-1:0] clip_out(logic [OffsetBits-1:0] v);
    logic [WideBits-1:0] w;
    w = WideBits'(v);
    return (w > WideBits'(17'h0FFFF)) ? {OutBits{1'b1}} : w[OutBits-1:0];
  endfunction

  function automatic logic [OffsetBits-1:0] span(logic [OffsetBits-1:0] e,
                                                  logic [OffsetBits-1:0] s);
    return (e > s) ? (e - s) : '0;
  endfunction

  function automatic tok_list_t push(tok_list_t l, tok_kind_e k, logic [7:0] c,
                                     logic [OffsetBits-1:0] s,
                                     logic [OffsetBits-1:0] len);
    token_t tk;
    tk.kind  = k;
    tk.chr   = c;
    tk.start = clip_out(s);
    tk.len   = clip_out(len);
    tk.last  = 1'b0;
    if (l.n != MaxToks) begin
      l.t[l.n] = tk;
      l.n      = l.n + 2'd1;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: sv/c_header_tokenizer_core.sv
// Top level of the C header tokenizer: byte stream in, token words out.
//
// Source text enters one byte per word on the slave stream (tlast marks the
// final byte of a text); token records leave on the master stream, one token
// per word, with tlast set on the final token a byte causes. Whitespace,
// '#' and '//' lines and block comments are skipped; identifiers (with a
// leading '~' and '::' qualification), the keyword extern, numbers, strings,
// ==, || and && and single characters become tokens. The last byte of a text
// flushes any open token and adds an EOF token, after which offsets restart
// at zero. Timing: a byte is scanned in the cycle it is accepted and its
// tokens (zero to three) land in a three-entry result register. A byte that
// causes n tokens holds the master port until all are out; bytes causing zero
// or one token stream at one per cycle when the master side keeps up, since
// the next byte is taken in the same cycle the last pending token is taken.
// The first token word appears in the cycle after its byte is accepted.
`default_nettype none

module c_header_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_text
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [3:0] token_kind, [11:4] token_char,
                                      // [27:12] token_start, [43:28] token_length,
                                      // [47:44] zero
  output logic        m_axis_tlast    // last_of_run
);
  import cht_pkg::*;

  scan_state_t state_q, state_d;
  tok_list_t   toks_d;
  token_t      res_q [3];
  logic [1:0]  cnt_q;
  logic [1:0]  head_q;
  token_t      cur;
  logic        s_fire;
  logic        m_fire;

  cht_step u_step (
    .state_i (state_q),
    .byte_i  (s_axis_tdata),
    .eot_i   (s_axis_tlast),
    .state_o (state_d),
    .toks_o  (toks_d)
  );

  // Take a new byte once at most one token is left and it leaves this cycle.
  assign m_axis_tvalid = (head_q != cnt_q);
  assign s_axis_tready = (head_q == cnt_q) ||
                         ((head_q + 2'd1 == cnt_q) && m_axis_tready);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  assign cur          = res_q[head_q];
  assign m_axis_tdata = {4'b0, cur.len, cur.start, cur.chr, cur.kind};
  assign m_axis_tlast = cur.last;

  // Scanner state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (s_fire) begin
      state_q <= state_d;
    end
  end

  // Result register: load all tokens of a byte, drain one per word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else if (s_fire) begin
      cnt_q  <= toks_d.n;
      head_q <= '0;
    end else if (m_fire) begin
      head_q <= head_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_q[0] <= toks_d.t[0];
      res_q[1] <= toks_d.t[1];
      res_q[2] <= toks_d.t[2];
    end
  end

endmodule

`default_nettype wire

FILE: sv/cht_step.sv
// Next-state and token logic for one source byte of the C header tokenizer.
`default_nettype none

module cht_step (
  input  cht_pkg::scan_state_t state_i,
  input  logic [7:0]           byte_i,
  input  logic                 eot_i,
  output cht_pkg::scan_state_t state_o,
  output cht_pkg::tok_list_t   toks_o
);
  import cht_pkg::*;

  scan_state_t           st;
  tok_list_t             tl;
  logic [OffsetBits-1:0] pos;
  logic [OffsetBits-1:0] end_pos;
  logic [OffsetBits-1:0] prev;
  logic                  do_disp;
  tok_kind_e             id_kind;
  tok_kind_e             num_kind;
  tok_kind_e             pair_kind;

  localparam logic [OffsetBits-1:0] LenOne = OffsetBits'(1);
  localparam logic [OffsetBits-1:0] LenTwo = OffsetBits'(2);

  always_comb begin
    st      = state_i;
    tl      = '0;
    pos     = state_i.pos;
    end_pos = (pos == PosMax) ? pos : pos + LenOne;
    prev    = (pos == '0) ? '0 : pos - LenOne;
    do_disp = 1'b0;

    pair_kind = (byte_i == ChEq) ? TOK_EQEQ : ((byte_i == ChBar) ? TOK_OR : TOK_AND);

    case (state_i.mode)
      MODE_LINE: begin
        if (byte_i == ChNl) st.mode = MODE_IDLE;
      end
      MODE_BLOCK: begin
        if (byte_i == ChStar) st.mode = MODE_BSTAR;
      end
      MODE_BSTAR: begin
        st.mode = (byte_i == ChSlash) ? MODE_IDLE :
                  ((byte_i == ChStar) ? MODE_BSTAR : MODE_BLOCK);
      end
      MODE_SLASH: begin
        if (byte_i == ChSlash) st.mode = MODE_LINE;
        else if (byte_i == ChStar) st.mode = MODE_BLOCK;
        else begin
          tl      = push(tl, TOK_SINGLE, ChSlash, st.start, LenOne);
          do_disp = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_word(byte_i)) begin
          st.kw = (st.kw < KwLen && byte_i == kw_char(st.kw)) ? st.kw + 3'd1 : KwNone;
        end else if (byte_i == ChColon) begin
          st.mode = MODE_ICOLON;
        end else begin
          id_kind = (st.kw == KwLen) ? TOK_KEYWORD : TOK_IDENT;
          tl      = push(tl, id_kind, 8'h00, st.start, span(pos, st.start));
          do_disp = 1'b1;
        end
      end
      MODE_ICOLON: begin
        if (byte_i == ChColon) begin
          st.kw   = KwNone;
          st.mode = MODE_IDCOLON;
        end else begin
          id_kind = (st.kw == KwLen) ? TOK_KEYWORD : TOK_IDENT;
          tl      = push(tl, id_kind, 8'h00, st.start, span(prev, st.start));
          tl      = push(tl, TOK_SINGLE, ChColon, prev, LenOne);
          st.mode = MODE_IDLE;
          do_disp = !eot_i;
        end
      end
      MODE_IDCOLON: begin
        if (is_ident_start(byte_i)) st.mode = MODE_IDENT;
        else begin
          id_kind = (st.kw == KwLen) ? TOK_KEYWORD : TOK_IDENT;
          tl      = push(tl, id_kind, 8'h00, st.start, span(pos, st.start));
          do_disp = 1'b1;
        end
      end
      MODE_NUMBER: begin
        num_kind = (st.nflags == NumDot) ? TOK_REAL : TOK_INT;
        if (byte_i == ChDot || byte_i == ChX) begin
          if (st.nflags == 2'd0) begin
            st.nflags = (byte_i == ChDot) ? NumDot : NumHex;
          end else begin
            tl      = push(tl, num_kind, 8'h00, st.start, span(pos, st.start));
            do_disp = 1'b1;
          end
        end else if (!is_word(byte_i) || byte_i == ChUnder) begin
          tl      = push(tl, num_kind, 8'h00, st.start, span(pos, st.start));
          do_disp = 1'b1;
        end
      end
      MODE_STRING: begin
        if (st.esc) st.esc = 1'b0;
        else if (byte_i == ChBslash) st.esc = 1'b1;
        else if (byte_i == ChQuote) begin
          tl      = push(tl, TOK_QUOTED, 8'h00, st.start, span(pos, st.start));
          st.mode = MODE_IDLE;
        end
      end
      MODE_PEND: begin
        if (byte_i == st.pend) begin
          tl      = push(tl, pair_kind, 8'h00, st.start, LenTwo);
          st.mode = MODE_IDLE;
        end else begin
          tl      = push(tl, TOK_SINGLE, st.pend, st.start, LenOne);
          do_disp = 1'b1;
        end
      end
      default: begin
        do_disp = 1'b1;
      end
    endcase

    // Start a fresh token from this byte.
    if (do_disp) begin
      st.mode = MODE_IDLE;
      if (is_space(byte_i)) begin
        st.mode = MODE_IDLE;
      end else if (byte_i == ChHash) begin
        st.mode = MODE_LINE;
      end else if (byte_i == ChSlash || byte_i == ChEq || byte_i == ChBar ||
                   byte_i == ChAmp) begin
        st.mode  = (byte_i == ChSlash) ? MODE_SLASH : MODE_PEND;
        st.pend  = byte_i;
        st.start = pos;
      end else if (is_ident_start(byte_i)) begin
        st.mode  = MODE_IDENT;
        st.start = pos;
        st.kw    = (byte_i == kw_char(3'd0)) ? 3'd1 : KwNone;
      end else if (is_digit(byte_i)) begin
        st.mode   = MODE_NUMBER;
        st.start  = pos;
        st.nflags = 2'd0;
      end else if (byte_i == ChQuote) begin
        st.mode  = MODE_STRING;
        st.start = end_pos;
        st.esc   = 1'b0;
      end else begin
        tl = push(tl, TOK_SINGLE, byte_i, pos, LenOne);
      end
    end

    id_kind  = (st.kw == KwLen) ? TOK_KEYWORD : TOK_IDENT;
    num_kind = (st.nflags == NumDot) ? TOK_REAL : TOK_INT;

    // End of text: flush the open token, then EOF, then back to reset.
    if (eot_i) begin
      case (st.mode)
        MODE_IDENT, MODE_IDCOLON: begin
          tl = push(tl, id_kind, 8'h00, st.start, span(end_pos, st.start));
        end
        MODE_ICOLON: begin
          tl = push(tl, id_kind, 8'h00, st.start, span(pos, st.start));
          tl = push(tl, TOK_SINGLE, ChColon, pos, LenOne);
        end
        MODE_NUMBER: begin
          tl = push(tl, num_kind, 8'h00, st.start, span(end_pos, st.start));
        end
        MODE_STRING: begin
          tl = push(tl, TOK_QUOTED, 8'h00, st.start, span(end_pos, st.start));
        end
        MODE_SLASH, MODE_PEND: begin
          tl = push(tl, TOK_SINGLE, st.pend, st.start, LenOne);
        end
        default: begin
        end
      endcase
      tl = push(tl, TOK_EOF, 8'h00, end_pos, '0);
      st = StateReset;
    end else begin
      st.pos = end_pos;
    end

    if (tl.n != 2'd0) tl.t[tl.n - 2'd1].last = 1'b1;

    state_o = st;
    toks_o  = tl;
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the C header tokenizer: directed and random byte texts in, token words checked.

module testbench;
  import cht_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } src_byte_t;

  localparam int unsigned PosTop   = (1 << OffsetBits) - 1;
  localparam int unsigned OutTop   = 16'hFFFF;
  localparam logic [47:0] KwBytes  = "extern";

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  c_header_tokenizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus and scoreboard storage.
  src_byte_t   bytes_to_send[$];
  logic [7:0]  text[$];
  token_t      tokens_due[$];
  token_t      step_toks[$];
  int unsigned useful_bytes = 0;
  int unsigned texts_built  = 0;
  int unsigned bytes_taken  = 0;
  int unsigned tokens_seen  = 0;
  int unsigned mismatches   = 0;

  // Scanner state of the predictor.
  mode_e       lx_mode;
  int unsigned lx_pos;
  int unsigned lx_start;
  logic [1:0]  lx_nflags;
  logic [2:0]  lx_kw;
  logic [7:0]  lx_pend;
  logic        lx_esc;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned sat_pos(int unsigned v);
    return (v > PosTop) ? PosTop : v;
  endfunction

  function automatic int unsigned gap(int unsigned e, int unsigned s);
    return (e > s) ? e - s : 0;
  endfunction

  function automatic logic blank(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic name_char(logic [7:0] b);
    return letter(b) || digit(b) || (b == ChUnder);
  endfunction

  function automatic logic name_head(logic [7:0] b);
    return letter(b) || (b == ChUnder) || (b == ChTilde);
  endfunction

  function automatic void clear_scanner();
    lx_mode   = MODE_IDLE;
    lx_pos    = 0;
    lx_start  = 0;
    lx_nflags = 2'd0;
    lx_kw     = 3'd0;
    lx_pend   = 8'h00;
    lx_esc    = 1'b0;
  endfunction

  // Drop anything past the third token of a byte; offsets clip at 16 bits.
  function automatic void add_token(tok_kind_e k, logic [7:0] c, int unsigned s,
                                    int unsigned n);
    token_t t;
    if (step_toks.size() < 3) begin
      t.kind  = k;
      t.chr   = c;
      t.start = (s > OutTop) ? 16'hFFFF : s[15:0];
      t.len   = (n > OutTop) ? 16'hFFFF : n[15:0];
      t.last  = 1'b0;
      step_toks.push_back(t);
    end
  endfunction

  function automatic void kw_step(logic [7:0] b);
    lx_kw = (lx_kw < KwLen && b == KwBytes[8*(5-lx_kw) +: 8]) ? lx_kw + 3'd1 : KwNone;
  endfunction

  function automatic void emit_name(int unsigned stop);
    add_token((lx_kw == KwLen) ? TOK_KEYWORD : TOK_IDENT, 8'h00, lx_start,
              gap(stop, lx_start));
  endfunction

  function automatic void emit_num(int unsigned stop);
    add_token((lx_nflags == NumDot) ? TOK_REAL : TOK_INT, 8'h00, lx_start,
              gap(stop, lx_start));
  endfunction

  // Classify a byte seen between tokens.
  function automatic void restart_scan(logic [7:0] b, int unsigned pos);
    lx_mode = MODE_IDLE;
    if (blank(b)) begin
    end else if (b == ChHash) begin
      lx_mode = MODE_LINE;
    end else if (b == ChSlash || b == ChEq || b == ChBar || b == ChAmp) begin
      lx_mode  = (b == ChSlash) ? MODE_SLASH : MODE_PEND;
      lx_pend  = b;
      lx_start = pos;
    end else if (name_head(b)) begin
      lx_mode  = MODE_IDENT;
      lx_start = pos;
      lx_kw    = 3'd0;
      kw_step(b);
    end else if (digit(b)) begin
      lx_mode   = MODE_NUMBER;
      lx_start  = pos;
      lx_nflags = 2'd0;
    end else if (b == ChQuote) begin
      lx_mode  = MODE_STRING;
      lx_start = sat_pos(pos + 1);
      lx_esc   = 1'b0;
    end else begin
      add_token(TOK_SINGLE, b, pos, 1);
    end
  endfunction

  // Advance the scanner by one accepted byte and queue the tokens it yields.
  function automatic void predict_tokens(logic [7:0] b, logic eot);
    int unsigned pos;
    int unsigned prev;
    int unsigned stop;
    pos  = lx_pos;
    prev = (pos > 0) ? pos - 1 : 0;
    stop = sat_pos(pos + 1);
    step_toks.delete();
    case (lx_mode)
      MODE_LINE: begin
        if (b == ChNl) lx_mode = MODE_IDLE;
      end
      MODE_BLOCK: begin
        if (b == ChStar) lx_mode = MODE_BSTAR;
      end
      MODE_BSTAR: begin
        lx_mode = (b == ChSlash) ? MODE_IDLE : (b == ChStar) ? MODE_BSTAR : MODE_BLOCK;
      end
      MODE_SLASH: begin
        if (b == ChSlash) lx_mode = MODE_LINE;
        else if (b == ChStar) lx_mode = MODE_BLOCK;
        else begin
          add_token(TOK_SINGLE, ChSlash, lx_start, 1);
          restart_scan(b, pos);
        end
      end
      MODE_IDENT: begin
        if (name_char(b)) kw_step(b);
        else if (b == ChColon) lx_mode = MODE_ICOLON;
        else begin
          emit_name(pos);
          restart_scan(b, pos);
        end
      end
      MODE_ICOLON: begin
        if (b == ChColon) begin
          lx_kw   = KwNone;
          lx_mode = MODE_IDCOLON;
        end else begin
          // single colon: name, then ':' on its own; at end of text the byte is lost
          emit_name(prev);
          add_token(TOK_SINGLE, ChColon, prev, 1);
          lx_mode = MODE_IDLE;
          if (!eot) restart_scan(b, pos);
        end
      end
      MODE_IDCOLON: begin
        if (name_head(b)) lx_mode = MODE_IDENT;
        else begin
          emit_name(pos);
          restart_scan(b, pos);
        end
      end
      MODE_NUMBER: begin
        if (b == ChDot || b == ChX) begin
          if (lx_nflags == 2'd0) lx_nflags = (b == ChDot) ? NumDot : NumHex;
          else begin
            emit_num(pos);
            restart_scan(b, pos);
          end
        end else if (!name_char(b) || b == ChUnder) begin
          emit_num(pos);
          restart_scan(b, pos);
        end
      end
      MODE_STRING: begin
        if (lx_esc) lx_esc = 1'b0;
        else if (b == ChBslash) lx_esc = 1'b1;
        else if (b == ChQuote) begin
          add_token(TOK_QUOTED, 8'h00, lx_start, gap(pos, lx_start));
          lx_mode = MODE_IDLE;
        end
      end
      MODE_PEND: begin
        if (b == lx_pend) begin
          add_token((b == ChEq) ? TOK_EQEQ : (b == ChBar) ? TOK_OR : TOK_AND,
                    8'h00, lx_start, 2);
          lx_mode = MODE_IDLE;
        end else begin
          add_token(TOK_SINGLE, lx_pend, lx_start, 1);
          restart_scan(b, pos);
        end
      end
      default: begin
        restart_scan(b, pos);
      end
    endcase

    if (eot) begin
      // flush the open token, then EOF; the next text restarts at offset zero
      case (lx_mode)
        MODE_IDENT, MODE_IDCOLON: emit_name(stop);
        MODE_ICOLON: begin
          emit_name(pos);
          add_token(TOK_SINGLE, ChColon, pos, 1);
        end
        MODE_NUMBER: emit_num(stop);
        MODE_STRING: add_token(TOK_QUOTED, 8'h00, lx_start, gap(stop, lx_start));
        MODE_SLASH, MODE_PEND: add_token(TOK_SINGLE, lx_pend, lx_start, 1);
        default: ;
      endcase
      add_token(TOK_EOF, 8'h00, stop, 0);
      clear_scanner();
    end else begin
      lx_pos = stop;
    end

    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t ns: token %0d, %s: got %0h, expected %0h", $time, tokens_seen, what,
               got, want);
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch("word with nothing expected, kind", 32'(m_axis_tdata[3:0]), 32'd0);
    end else begin
      want = tokens_due.pop_front();
      if (m_axis_tdata[3:0] != want.kind)
        report_mismatch("kind", 32'(m_axis_tdata[3:0]), 32'(want.kind));
      if (m_axis_tdata[11:4] != want.chr)
        report_mismatch("char", 32'(m_axis_tdata[11:4]), 32'(want.chr));
      if (m_axis_tdata[27:12] != want.start)
        report_mismatch("start", 32'(m_axis_tdata[27:12]), 32'(want.start));
      if (m_axis_tdata[43:28] != want.len)
        report_mismatch("length", 32'(m_axis_tdata[43:28]), 32'(want.len));
      if (m_axis_tdata[47:44] != 4'h0)
        report_mismatch("padding", 32'(m_axis_tdata[47:44]), 32'd0);
      if (m_axis_tlast != want.last)
        report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
    end
    tokens_seen++;
  endtask

  // Predict on every accepted byte, check every accepted token word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tokens(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) check_token();
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver: bursts of random length, random gaps, some long unbroken runs
  // ---------------------------------------------------------------------------
  src_byte_t   next_byte;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0 || bytes_to_send.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        next_byte = bytes_to_send.pop_front();
        s_axis_tdata  <= next_byte.b;
        s_axis_tlast  <= next_byte.eot;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else if ($urandom_range(3) == 0) begin
          burst_left <= $urandom_range(40, 200);
          gap_left   <= 0;
        end else begin
          burst_left <= $urandom_range(1, 10);
          gap_left   <= $urandom_range(0, 6);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token receiver: rotate a stall pattern, reload it when a random countdown runs out
  // ---------------------------------------------------------------------------
  logic [15:0] ready_bits = 16'hFFFF;
  int unsigned ready_tick = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ready_bits[0];
      if (ready_tick == 0) begin
        case ($urandom_range(3))
          0:       ready_bits <= 16'hFFFF;
          1:       ready_bits <= 16'($urandom);
          2:       ready_bits <= 16'($urandom & $urandom);
          default: ready_bits <= 16'($urandom | $urandom);
        endcase
        ready_tick <= $urandom_range(20, 120);
      end else begin
        ready_bits <= {ready_bits[0], ready_bits[15:1]};
        ready_tick <= ready_tick - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  task automatic put(logic [7:0] c);
    text.push_back(c);
    useful_bytes++;
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] head_char();
    int unsigned r;
    r = $urandom_range(52);
    if (r < 26) return 8'(8'h61 + r);
    else if (r < 52) return 8'(8'h41 + r - 26);
    else return ChUnder;
  endfunction

  function automatic logic [7:0] body_char();
    int unsigned r;
    r = $urandom_range(62);
    return (r < 10) ? 8'(8'h30 + r) : head_char();
  endfunction

  task automatic put_space();
    int unsigned r;
    r = $urandom_range(9);
    put((r < 5) ? 8'h20 : 8'(8'h04 + r));
  endtask

  task automatic put_name();
    case ($urandom_range(5))
      0: put_str("extern");
      1: begin
        if ($urandom_range(1)) put_str("exte");
        else put_str("externx");
      end
      default: begin
        if ($urandom_range(3) == 0) put(ChTilde);
        put(head_char());
        repeat ($urandom_range(6)) put(body_char());
      end
    endcase
  endtask

  task automatic put_number();
    int unsigned r;
    put(8'(8'h30 + $urandom_range(9)));
    repeat ($urandom_range(6)) begin
      r = $urandom_range(9);
      case (r)
        5:       put(ChDot);
        6:       put(ChX);
        7:       put(head_char());
        8:       put(ChUnder);
        default: put(8'(8'h30 + $urandom_range(9)));
      endcase
    end
  endtask

  task automatic put_string();
    logic [7:0] c;
    put(ChQuote);
    repeat ($urandom_range(8)) begin
      if ($urandom_range(7) == 0) begin
        put(ChBslash);
        put(any_byte());
      end else begin
        c = any_byte();
        put((c == ChQuote || c == ChBslash) ? 8'h61 : c);
      end
    end
    // leave some strings open so a later quote or the end of text closes them
    if ($urandom_range(7) != 0) put(ChQuote);
  endtask

  // Comment bodies are skipped by the block, so they are not counted as useful.
  task automatic put_comment();
    case ($urandom_range(2))
      0: text.push_back(ChHash);
      1: begin
        text.push_back(ChSlash);
        text.push_back(ChSlash);
      end
      default: begin
        text.push_back(ChSlash);
        text.push_back(ChStar);
        repeat ($urandom_range(10)) begin
          text.push_back(($urandom_range(3) == 0) ? ChStar : 8'($urandom_range(8'h20, 8'h7E)));
        end
        text.push_back(ChStar);
        text.push_back(ChSlash);
      end
    endcase
    if (text[text.size() - 1] != ChSlash || text[text.size() - 2] != ChStar) begin
      repeat ($urandom_range(8)) text.push_back(8'($urandom_range(8'h20, 8'h7E)));
      text.push_back(ChNl);
    end
  endtask

  task automatic put_fragment();
    case ($urandom_range(9))
      0, 1: put_name();
      2: begin
        // qualified name, sometimes with nothing usable after the '::'
        put_name();
        put(ChColon);
        put(ChColon);
        if ($urandom_range(3) != 0) put_name();
        else put(any_byte());
      end
      3: begin
        put_name();
        put(ChColon);
        if ($urandom_range(1)) put_name();
      end
      4: put_number();
      5: put_string();
      6: begin
        case ($urandom_range(7))
          0: put_str("==");
          1: put_str("||");
          2: put_str("&&");
          3: put(ChEq);
          4: put(ChBar);
          5: put(ChAmp);
          6: put(ChSlash);
          default: begin
            put(ChEq);
            put(ChBar);
          end
        endcase
      end
      7: put_comment();
      8: put(any_byte());
      default: put(8'($urandom_range(8'h21, 8'h7E)));
    endcase
  endtask

  // Mark the final byte of the text as end of text and queue it for sending.
  task automatic flush_text();
    src_byte_t sb;
    foreach (text[i]) begin
      sb.b   = text[i];
      sb.eot = (i == text.size() - 1);
      bytes_to_send.push_back(sb);
    end
    text.delete();
    texts_built++;
  endtask

  task automatic build_directed();
    // colon at end: name, ':', then a byte that gets dropped; top byte value
    put_str("x:");
    put(8'hFF);
    flush_text();
    // a lone zero byte right after an EOF
    put(8'h00);
    flush_text();
    // keyword, '~' name with dangling '::', double with a second dot, pairs,
    // and a string left open on an escaped quote
    put_str("extern ~a::1 2.3.==||&&\"\\\"");
    flush_text();
    // line comment, single colon, block comment left open
    put_str("#\na:b/*");
    flush_text();
  endtask

  task automatic build_random();
    logic [7:0] c;
    while (bytes_to_send.size() < 300) begin
      repeat ($urandom_range(1, 8)) begin
        put_fragment();
        if ($urandom_range(2) != 0) put_space();
      end
      if ($urandom_range(7) == 0) begin
        put_name();
        put(ChColon);
        c = any_byte();
        put((c == ChColon) ? 8'h2C : c);
      end
      flush_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    clear_scanner();
    build_directed();
    build_random();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (bytes_to_send.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes (%0d outside comments) in %0d texts, checked %0d token words.",
             bytes_taken, useful_bytes, texts_built, tokens_seen);
    $display("Texts mixed names, keywords, numbers, strings, pairs, comments and raw bytes;");
    $display("%0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d bytes unsent and %0d token words outstanding.",
             bytes_to_send.size(), tokens_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
